>>> sv/trs_pkg.sv
`default_nettype none
package trs_pkg;

   localparam int NUM_INSTRUMENTS  = 15;
   localparam int ROWS_PER_PATTERN = 64;
   localparam int NOTE_LIMIT       = 72;
   localparam int MAX_RESULTS      = 5;
   localparam int SLOT_WIDTH       = 4;
   localparam int ROW_WIDTH        = 6;
   localparam int NOTE_IDX_WIDTH   = 7;
   localparam int COUNT_WIDTH      = 3;
   localparam int CSR_INDEX_WIDTH  = 2;

   localparam logic [3:0] EFFECT_PORTA = 4'h3;

   // register targets
   localparam logic [2:0] TGT_SWEEP1 = 3'd0;
   localparam logic [2:0] TGT_DUTY1  = 3'd1;
   localparam logic [2:0] TGT_FREQ1  = 3'd2;
   localparam logic [2:0] TGT_DUTY2  = 3'd3;
   localparam logic [2:0] TGT_FREQ2  = 3'd4;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TICKS_PER_ROW = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORDER_COUNT   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MUTE_MASK     = 2'd2;

   localparam logic [7:0] TICKS_PER_ROW_RESET = 8'd6;
   localparam logic [7:0] ORDER_COUNT_RESET   = 8'd1;

   localparam logic [10:0] NOTE_PERIOD [0:NOTE_LIMIT-1] = '{
      11'd44,   11'd156,  11'd262,  11'd363,  11'd457,  11'd547,
      11'd631,  11'd710,  11'd786,  11'd854,  11'd923,  11'd986,
      11'd1046, 11'd1102, 11'd1155, 11'd1205, 11'd1253, 11'd1297,
      11'd1339, 11'd1379, 11'd1417, 11'd1452, 11'd1486, 11'd1517,
      11'd1546, 11'd1575, 11'd1602, 11'd1627, 11'd1650, 11'd1673,
      11'd1694, 11'd1714, 11'd1732, 11'd1750, 11'd1767, 11'd1783,
      11'd1798, 11'd1812, 11'd1825, 11'd1837, 11'd1849, 11'd1860,
      11'd1871, 11'd1881, 11'd1890, 11'd1899, 11'd1907, 11'd1915,
      11'd1923, 11'd1930, 11'd1936, 11'd1943, 11'd1949, 11'd1954,
      11'd1959, 11'd1964, 11'd1969, 11'd1974, 11'd1978, 11'd1982,
      11'd1985, 11'd1988, 11'd1992, 11'd1995, 11'd1998, 11'd2001,
      11'd2004, 11'd2006, 11'd2009, 11'd2011, 11'd2013, 11'd2015
   };

   typedef struct packed {
      logic       kind;
      logic [7:0] note_a;
      logic [7:0] fx_a;
      logic [7:0] note_b;
      logic [7:0] fx_b;
      logic [3:0] instr_slot;
      logic [7:0] instr_sweep;
      logic [7:0] instr_duty;
      logic [7:0] instr_envelope;
      logic [7:0] instr_highmask;
   } req_type;

   typedef struct packed {
      logic                 write_valid;
      logic [2:0]           write_target;
      logic [15:0]          write_value;
      logic                 last;
      logic [7:0]           order_now;
      logic [ROW_WIDTH-1:0] row_now;
      logic [7:0]           tick_now;
   } rsp_type;

   typedef struct packed {
      logic        write_valid;
      logic [2:0]  target;
      logic [15:0] value;
   } wr_type;

   // registered item between the front end and the core
   typedef struct packed {
      logic        valid;
      req_type     req;
      logic [31:0] entry_a;
      logic [31:0] entry_b;
   } stage_type;

   // all results of one item
   typedef struct packed {
      wr_type [MAX_RESULTS-1:0] wr;
      logic [COUNT_WIDTH-1:0]   count;
      logic [7:0]               order_now;
      logic [ROW_WIDTH-1:0]     row_now;
      logic [7:0]               tick_now;
   } bundle_type;

endpackage
`default_nettype wire

>>> sv/tracker_row_sequencer.sv
`default_nettype none
// channel   direction  handshake          payload
// req       in         req_valid/stall    req_data: tick or instrument load
// rsp       out        rsp_valid/stall    rsp_data: one register write or idle
// csr       in         csr_valid/ready    csr_index, csr_data
//
// an item enters the input register, then the row logic builds all of its
// results combinationally; the output stage sends them one per cycle while rsp
// is not stalled, so an item with n writes gives max(n,1) responses (at most 5)
// items are accepted every cycle while the output stage keeps up
// reset restores the registers and position; the instrument store is not cleared
// stall on rsp holds the output stage and backs up into req
module tracker_row_sequencer
   import trs_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire req_type                    req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output rsp_type                         rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [7:0]                 csr_data
);

   stage_type  stage;
   bundle_type bundle;
   logic       bundle_free;
   logic       fire;

   assign csr_ready = 1'b1;
   assign fire      = stage.valid && bundle_free;

   trs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .fire      (fire),
      .stage     (stage)
   );

   trs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .fire      (fire),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .bundle    (bundle)
   );

   trs_emitter u_emitter (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .bundle_in   (bundle),
      .bundle_free (bundle_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

>>> sv/trs_front.sv
`default_nettype none
module trs_front
   import trs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   input  wire logic    fire,
   output stage_type    stage
);

   logic                  valid_ff;
   req_type               req_ff;
   logic [31:0]           entry_a_ff;
   logic [31:0]           entry_b_ff;
   logic [31:0]           mem [NUM_INSTRUMENTS];
   logic                  accept;
   logic [SLOT_WIDTH-1:0] addr_a;
   logic [SLOT_WIDTH-1:0] addr_b;
   logic [SLOT_WIDTH-1:0] id_a;
   logic [SLOT_WIDTH-1:0] id_b;

   assign req_stall = valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   assign id_a   = req_data.fx_a[7:4];
   assign id_b   = req_data.fx_b[7:4];
   // id 0 reads nothing useful, keep the address in range
   assign addr_a = (id_a == '0) ? '0 : id_a - 1'b1;
   assign addr_b = (id_b == '0) ? '0 : id_b - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (fire) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff     <= req_data;
         entry_a_ff <= mem[addr_a];
         entry_b_ff <= mem[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.kind &&
          ({1'b0, req_data.instr_slot} < (SLOT_WIDTH+1)'(NUM_INSTRUMENTS))) begin
         mem[req_data.instr_slot] <= {req_data.instr_highmask, req_data.instr_envelope,
                                      req_data.instr_duty, req_data.instr_sweep};
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.req     = req_ff;
   assign stage.entry_a = entry_a_ff;
   assign stage.entry_b = entry_b_ff;

endmodule
`default_nettype wire

>>> sv/trs_core.sv
`default_nettype none
module trs_core
   import trs_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire stage_type                  stage,
   input  wire logic                       fire,
   input  wire logic                       csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [7:0]                 csr_data,
   output bundle_type                      bundle
);

   logic [7:0]           ticks_per_row_ff;
   logic [7:0]           order_count_ff;
   logic [1:0]           mute_ff;
   logic [7:0]           tick_ff, tick_in;
   logic [ROW_WIDTH-1:0] row_ff, row_in;
   logic [7:0]           order_ff, order_in;
   logic [10:0]          period_a_ff, period_a_in;
   logic [10:0]          period_b_ff, period_b_in;
   logic [7:0]           hm_a_ff, hm_a_in;
   logic [7:0]           hm_b_ff, hm_b_in;

   logic                    act_a, act_b;
   logic [3:0]              id_a, id_b;
   logic [NOTE_IDX_WIDTH-1:0] nidx_a, nidx_b;
   logic [MAX_RESULTS-1:0]  en;
   wr_type                  cand [MAX_RESULTS];
   logic [7:0]              tick_sum;
   logic [ROW_WIDTH:0]      row_sum;
   logic [7:0]              order_sum;
   logic [COUNT_WIDTH-1:0]  n;

   assign act_a  = !stage.req.kind && (tick_ff == '0) && (stage.req.note_a < 8'(NOTE_LIMIT));
   assign act_b  = !stage.req.kind && (tick_ff == '0) && (stage.req.note_b < 8'(NOTE_LIMIT));
   assign id_a   = stage.req.fx_a[7:4];
   assign id_b   = stage.req.fx_b[7:4];
   assign nidx_a = act_a ? stage.req.note_a[NOTE_IDX_WIDTH-1:0] : '0;
   assign nidx_b = act_b ? stage.req.note_b[NOTE_IDX_WIDTH-1:0] : '0;

   always_comb begin
      period_a_in = period_a_ff;
      hm_a_in     = hm_a_ff;
      if (act_a) begin
         if (stage.req.fx_a[3:0] != EFFECT_PORTA) begin
            period_a_in = NOTE_PERIOD[nidx_a];
         end
         if (id_a == '0) begin
            hm_a_in = hm_a_ff & 8'h7F;
         end else if (!mute_ff[0]) begin
            hm_a_in = stage.entry_a[31:24];
         end
      end
      period_b_in = period_b_ff;
      hm_b_in     = hm_b_ff;
      if (act_b) begin
         if (stage.req.fx_b[3:0] != EFFECT_PORTA) begin
            period_b_in = NOTE_PERIOD[nidx_b];
         end
         if (id_b == '0) begin
            hm_b_in = hm_b_ff & 8'h7F;
         end else if (!mute_ff[1]) begin
            hm_b_in = stage.entry_b[31:24];
         end
      end
   end

   assign en[0] = act_a && (id_a != '0) && !mute_ff[0];
   assign en[1] = en[0];
   assign en[2] = act_a && !mute_ff[0];
   assign en[3] = act_b && (id_b != '0) && !mute_ff[1];
   assign en[4] = act_b && !mute_ff[1];

   always_comb begin
      cand[0] = '{1'b1, TGT_SWEEP1, {8'h00, stage.entry_a[7:0]}};
      cand[1] = '{1'b1, TGT_DUTY1, stage.entry_a[23:8]};
      cand[2] = '{1'b1, TGT_FREQ1,
                  {hm_a_in | {5'b0, period_a_in[10:8]}, period_a_in[7:0]}};
      cand[3] = '{1'b1, TGT_DUTY2, stage.entry_b[23:8]};
      cand[4] = '{1'b1, TGT_FREQ2,
                  {hm_b_in | {5'b0, period_b_in[10:8]}, period_b_in[7:0]}};
   end

   // position after the step
   always_comb begin
      tick_sum  = tick_ff + 8'd1;
      row_sum   = {1'b0, row_ff} + 1'b1;
      order_sum = order_ff + 8'd1;
      tick_in   = tick_ff;
      row_in    = row_ff;
      order_in  = order_ff;
      if (!stage.req.kind) begin
         tick_in = tick_sum;
         if (tick_sum == ticks_per_row_ff) begin
            tick_in = '0;
            row_in  = row_sum[ROW_WIDTH-1:0];
            if (row_sum >= (ROW_WIDTH+1)'(ROWS_PER_PATTERN)) begin
               row_in   = '0;
               order_in = (order_sum == order_count_ff) ? 8'd0 : order_sum;
            end
         end
      end
   end

   // pack enabled writes to the front of the list
   always_comb begin
      bundle.wr = '0;
      n         = '0;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (en[k]) begin
            bundle.wr[n] = cand[k];
            n            = n + 1'b1;
         end
      end
      bundle.count     = (n == '0) ? COUNT_WIDTH'(1) : n;
      bundle.order_now = order_in;
      bundle.row_now   = row_in;
      bundle.tick_now  = tick_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= '0;
         row_ff      <= '0;
         order_ff    <= '0;
         period_a_ff <= '0;
         period_b_ff <= '0;
         hm_a_ff     <= '0;
         hm_b_ff     <= '0;
      end else if (fire) begin
         tick_ff     <= tick_in;
         row_ff      <= row_in;
         order_ff    <= order_in;
         period_a_ff <= period_a_in;
         period_b_ff <= period_b_in;
         hm_a_ff     <= hm_a_in;
         hm_b_ff     <= hm_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_row_ff <= TICKS_PER_ROW_RESET;
         order_count_ff   <= ORDER_COUNT_RESET;
         mute_ff          <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TICKS_PER_ROW: ticks_per_row_ff <= csr_data;
            CSR_ORDER_COUNT:   order_count_ff   <= csr_data;
            CSR_MUTE_MASK:     mute_ff          <= csr_data[1:0];
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

>>> sv/trs_emitter.sv
`default_nettype none
module trs_emitter
   import trs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire bundle_type bundle_in,
   output logic            bundle_free,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data
);

   logic                   valid_ff;
   bundle_type             bundle_ff;
   logic [COUNT_WIDTH-1:0] idx_ff;
   logic                   at_last;
   logic                   taken;
   wr_type                 cur;

   assign at_last     = (idx_ff == bundle_ff.count - 1'b1);
   assign taken       = valid_ff && !rsp_stall;
   assign bundle_free = !valid_ff || (taken && at_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (fire) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (taken) begin
         if (at_last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         bundle_ff <= bundle_in;
      end
   end

   assign cur = bundle_ff.wr[idx_ff];

   assign rsp_valid             = valid_ff;
   assign rsp_data.write_valid  = cur.write_valid;
   assign rsp_data.write_target = cur.target;
   assign rsp_data.write_value  = cur.value;
   assign rsp_data.last         = at_last;
   assign rsp_data.order_now    = bundle_ff.order_now;
   assign rsp_data.row_now      = bundle_ff.row_now;
   assign rsp_data.tick_now     = bundle_ff.tick_now;

endmodule
`default_nettype wire

>>> tb/tracker_row_sequencer_score.sv
`timescale 1ns / 100ps
module tracker_row_sequencer_score
   import trs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  req_type                    req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  rsp_type                    rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                 csr_data,
   output int                         fail_count,
   output int                         pending
);

   typedef struct packed {
      logic [7:0] gate;
      logic [7:0] envelope;
      logic [7:0] duty;
      logic [7:0] sweep;
   } voice_type;

   localparam logic [10:0] PITCH_PERIOD [NOTE_LIMIT] = '{
      11'd44,   11'd156,  11'd262,  11'd363,  11'd457,  11'd547,
      11'd631,  11'd710,  11'd786,  11'd854,  11'd923,  11'd986,
      11'd1046, 11'd1102, 11'd1155, 11'd1205, 11'd1253, 11'd1297,
      11'd1339, 11'd1379, 11'd1417, 11'd1452, 11'd1486, 11'd1517,
      11'd1546, 11'd1575, 11'd1602, 11'd1627, 11'd1650, 11'd1673,
      11'd1694, 11'd1714, 11'd1732, 11'd1750, 11'd1767, 11'd1783,
      11'd1798, 11'd1812, 11'd1825, 11'd1837, 11'd1849, 11'd1860,
      11'd1871, 11'd1881, 11'd1890, 11'd1899, 11'd1907, 11'd1915,
      11'd1923, 11'd1930, 11'd1936, 11'd1943, 11'd1949, 11'd1954,
      11'd1959, 11'd1964, 11'd1969, 11'd1974, 11'd1978, 11'd1982,
      11'd1985, 11'd1988, 11'd1992, 11'd1995, 11'd1998, 11'd2001,
      11'd2004, 11'd2006, 11'd2009, 11'd2011, 11'd2013, 11'd2015
   };

   // song settings
   logic [7:0] row_len;
   logic [7:0] song_len;
   logic [1:0] silenced;

   // playback position and channel state
   logic [7:0]           beat;
   logic [ROW_WIDTH-1:0] line;
   logic [7:0]           song_pos;
   logic [10:0]          pitch [2];
   logic [7:0]           gate_bits [2];
   voice_type            voice_bank [NUM_INSTRUMENTS];

   rsp_type row_writes[$];
   rsp_type pending_writes[$];

   task automatic add_write(input logic [2:0] target, input logic [15:0] value);
      rsp_type r;
      r = '0;
      r.write_valid  = 1'b1;
      r.write_target = target;
      r.write_value  = value;
      row_writes.push_back(r);
   endtask

   task automatic play_channel(input int ch, input logic [7:0] note, input logic [7:0] fx);
      logic      muted;
      logic [3:0] id;
      voice_type v;
      logic [10:0] p;
      muted = silenced[ch];
      if (note >= NOTE_LIMIT) return;
      if (fx[3:0] != EFFECT_PORTA) pitch[ch] = PITCH_PERIOD[note[6:0]];
      id = fx[7:4];
      if (id == 4'd0) begin
         gate_bits[ch][7] = 1'b0;
      end else if (!muted) begin
         v = voice_bank[id - 4'd1];
         if (ch == 0) begin
            add_write(TGT_SWEEP1, {8'h00, v.sweep});
            add_write(TGT_DUTY1, {v.envelope, v.duty});
         end else begin
            add_write(TGT_DUTY2, {v.envelope, v.duty});
         end
         gate_bits[ch] = v.gate;
      end
      if (!muted) begin
         p = pitch[ch];
         add_write(ch == 0 ? TGT_FREQ1 : TGT_FREQ2,
                   {gate_bits[ch] | {5'b00000, p[10:8]}, p[7:0]});
      end
   endtask

   task automatic advance_position;
      beat = beat + 8'd1;
      if (beat == row_len) begin
         beat = 8'd0;
         if (line == ROW_WIDTH'(ROWS_PER_PATTERN - 1)) begin
            line     = '0;
            song_pos = song_pos + 8'd1;
            if (song_pos == song_len) song_pos = 8'd0;
         end else begin
            line = line + 1'b1;
         end
      end
   endtask

   task automatic play_item(input req_type it);
      rsp_type r;
      row_writes.delete();
      if (it.kind) begin
         if (it.instr_slot < NUM_INSTRUMENTS)
            voice_bank[it.instr_slot] = {it.instr_highmask, it.instr_envelope,
                                         it.instr_duty, it.instr_sweep};
      end else begin
         if (beat == 8'd0) begin
            play_channel(0, it.note_a, it.fx_a);
            play_channel(1, it.note_b, it.fx_b);
         end
         advance_position();
      end
      if (row_writes.size() == 0) begin
         r = '0;
         row_writes.push_back(r);
      end
      foreach (row_writes[k]) begin
         r           = row_writes[k];
         r.last      = (k == row_writes.size() - 1);
         r.order_now = song_pos;
         r.row_now   = line;
         r.tick_now  = beat;
         pending_writes.push_back(r);
      end
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_writes.size() == 0) begin
         fail_count++;
         $display("%0t: unexpected result, expected none, got %h", $time, got);
         return;
      end
      want = pending_writes.pop_front();
      compare_field("write_valid", int'(want.write_valid), int'(got.write_valid));
      compare_field("write_target", int'(want.write_target), int'(got.write_target));
      compare_field("write_value", int'(want.write_value), int'(got.write_value));
      compare_field("last", int'(want.last), int'(got.last));
      compare_field("order_now", int'(want.order_now), int'(got.order_now));
      compare_field("row_now", int'(want.row_now), int'(got.row_now));
      compare_field("tick_now", int'(want.tick_now), int'(got.tick_now));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         row_len      = TICKS_PER_ROW_RESET;
         song_len     = ORDER_COUNT_RESET;
         silenced     = 2'b00;
         beat         = 8'd0;
         line         = '0;
         song_pos     = 8'd0;
         pitch[0]     = '0;
         pitch[1]     = '0;
         gate_bits[0] = '0;
         gate_bits[1] = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TICKS_PER_ROW: row_len  = csr_data;
               CSR_ORDER_COUNT:   song_len = csr_data;
               CSR_MUTE_MASK:     silenced = csr_data[1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) play_item(req_data);
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
      end
      pending = pending_writes.size();
   end

endmodule

>>> tb/tracker_row_sequencer_tb.sv
`timescale 1ns / 100ps
module tracker_row_sequencer_tb;
   import trs_pkg::*;

   localparam int BACKLOG_CYCLES = 60;
   localparam int IDLE_PCT       = 18;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   req_type                    req_data;
   logic                       rsp_valid;
   logic                       rsp_stall;
   rsp_type                    rsp_data;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [7:0]                 csr_data;

   int fail_count;
   int pending;
   int req_idle_pct;
   int rsp_idle_pct;
   int backlog_asked;
   int backlog_done;
   int ticks_sent;
   int loads_sent;
   int settings_used;

   tracker_row_sequencer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   tracker_row_sequencer_score score (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic req_type mk_tick(input logic [7:0] na, input logic [7:0] fa,
                                       input logic [7:0] nb, input logic [7:0] fb);
      req_type it;
      it        = '0;
      it.note_a = na;
      it.fx_a   = fa;
      it.note_b = nb;
      it.fx_b   = fb;
      return it;
   endfunction

   function automatic req_type mk_load(input logic [3:0] slot, input logic [7:0] sweep,
                                       input logic [7:0] duty, input logic [7:0] env,
                                       input logic [7:0] gate);
      req_type it;
      it                = '0;
      it.kind           = 1'b1;
      it.instr_slot     = slot;
      it.instr_sweep    = sweep;
      it.instr_duty     = duty;
      it.instr_envelope = env;
      it.instr_highmask = gate;
      return it;
   endfunction

   function automatic logic [7:0] pick_note(input int rest_pct);
      if ($urandom_range(99) < rest_pct) return 8'($urandom_range(255, NOTE_LIMIT));
      return 8'($urandom_range(NOTE_LIMIT - 1));
   endfunction

   function automatic logic [7:0] pick_fx;
      logic [7:0] fx;
      fx = 8'($urandom);
      // lean toward trigger clears and portamento
      if ($urandom_range(3) == 0) fx[7:4] = 4'h0;
      if ($urandom_range(5) == 0) fx[3:0] = EFFECT_PORTA;
      return fx;
   endfunction

   function automatic req_type random_item(input int load_pct, input int rest_pct);
      req_type it;
      it.kind           = ($urandom_range(99) < load_pct);
      it.note_a         = pick_note(rest_pct);
      it.fx_a           = pick_fx();
      it.note_b         = pick_note(rest_pct);
      it.fx_b           = pick_fx();
      it.instr_slot     = 4'($urandom);
      it.instr_sweep    = 8'($urandom);
      it.instr_duty     = 8'($urandom);
      it.instr_envelope = 8'($urandom);
      it.instr_highmask = 8'($urandom);
      return it;
   endfunction

   // returns at the falling edge after the item went in, valid still high
   task automatic send_item(input req_type it);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      @(negedge clock);
      if (it.kind) loads_sent++;
      else ticks_sent++;
   endtask

   task automatic run_random(input int count, input int load_pct, input int rest_pct);
      repeat (count) send_item(random_item(load_pct, rest_pct));
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_put(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      @(negedge clock);
   endtask

   task automatic set_song(input logic [7:0] row_len, input logic [7:0] song_len,
                           input logic [1:0] mask);
      drain_results();
      csr_put(CSR_TICKS_PER_ROW, row_len);
      csr_put(CSR_ORDER_COUNT, song_len);
      csr_put(CSR_MUTE_MASK, {6'b000000, mask});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (backlog_done != backlog_asked) begin
            backlog_done++;
            rsp_stall <= 1'b1;
            repeat (BACKLOG_CYCLES) @(negedge clock);
         end
         rsp_stall <= (rsp_idle_pct != 0) && ($urandom_range(99) < rsp_idle_pct);
      end
   end

   initial begin
      #10_000_000;
      $display("tracker_row_sequencer_tb failed");
      $finish;
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one tick per row so every tick plays the cells
      set_song(8'd1, 8'd2, 2'b00);

      // fill the whole instrument bank, then a load to the slot past the end
      for (int s = 0; s < NUM_INSTRUMENTS; s++) begin
         case (s)
            0:       send_item(mk_load(4'(s), 8'hFF, 8'hFF, 8'hFF, 8'hFF));
            1:       send_item(mk_load(4'(s), 8'h00, 8'h00, 8'h00, 8'h00));
            2:       send_item(mk_load(4'(s), 8'h7F, 8'h80, 8'h01, 8'h80));
            3:       send_item(mk_load(4'(s), 8'h80, 8'h3F, 8'hF0, 8'h40));
            default: send_item(mk_load(4'(s), 8'($urandom), 8'($urandom),
                                       8'($urandom), 8'($urandom)));
         endcase
      end
      send_item(mk_load(4'hF, 8'hAA, 8'h55, 8'hAA, 8'hC0));

      send_item(mk_tick(8'd0, 8'h10, 8'd71, 8'hF0));    // all five writes
      send_item(mk_tick(8'd72, 8'h00, 8'd255, 8'hFF));  // both channels rest
      send_item(mk_tick(8'd5, 8'h13, 8'd40, 8'h23));    // portamento keeps period
      send_item(mk_tick(8'd10, 8'h00, 8'd11, 8'h03));   // id 0 clears trigger
      send_item(mk_tick(8'd0, 8'hFF, 8'd71, 8'hF3));
      send_item(mk_tick(8'd127, 8'h2F, 8'd0, 8'h30));
      send_item(mk_tick(8'd71, 8'h33, 8'd72, 8'h10));

      for (int m = 1; m < 4; m++) begin
         set_song(8'd1, 8'd2, 2'(m));
         send_item(mk_tick(8'd3, 8'h40, 8'd4, 8'h50));
         send_item(mk_tick(8'd6, 8'h00, 8'd7, 8'h13));
         send_item(mk_tick(8'd8, 8'h43, 8'd9, 8'h00));
      end

      // no idling here, with a long output hold-off in the middle
      set_song(8'd1, 8'd2, 2'b00);
      run_random(20, 15, 20);
      backlog_asked++;
      run_random(25, 0, 10);
      drain_results();
      run_random(20, 15, 20);

      req_idle_pct = IDLE_PCT;
      rsp_idle_pct = IDLE_PCT;
      set_song(8'd6, 8'd255, 2'($urandom));
      run_random(40, 10, 25);
      set_song(8'd2, 8'd1, 2'b00);
      run_random(40, 10, 25);

      // one tick per row again so the order index moves on and wraps at the count
      set_song(8'd1, 8'd2, 2'b00);
      run_random(80, 5, 40);

      set_song(8'd3, 8'd4, 2'b01);
      run_random(25, 10, 25);

      drain_results();
      repeat (10) @(negedge clock);
      $display("covered %0d ticks and %0d instrument loads over %0d song settings",
               ticks_sent, loads_sent, settings_used);
      $display("row lengths 1, 2, 3 and 6, order wrap at the count, all mute masks");
      if (fail_count == 0 && pending == 0) begin
         $display("tracker_row_sequencer_tb passed");
      end else begin
         $display("tracker_row_sequencer_tb failed");
      end
      $finish;
   end

endmodule
